// File: design/assert_macros.svh
// Assertion macros used by sorted_key_table_remove_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SKT_ASSERT_NOW(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SKT_ASSERT_NEXT(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

// File: design/skt_pkg.sv
package skt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int ENTRY_W     = 2 * KEY_W;

  // Input word kinds
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_REMOVED  = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_APPENDED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;       // latch key, open search range
    logic       append;     // write key at end of table
    logic       probe;      // read entry at middle of range
    logic       narrow;     // shrink range after a miss
    logic       hit;        // start shifting after the found entry
    logic       shift;      // one step of the shift-down sweep
    logic       fin;        // post result word
    logic [1:0] fin_status;
  } skt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic search_done;
    logic key_eq;
    logic shift_more;
  } skt_stat_t;

endpackage

// File: design/sorted_key_table_remove_unit.sv
// Sorted key table with append and remove-by-search.
// Input channel: drive kind, key_primary and key_secondary with start high;
// the word is taken at the rising edge where start is high and busy is low.
// kind 0 appends the key at the table end (order is the loader's duty),
// kind 1 binary-searches the key and removes the first equal entry probed.
// Result channel: done pulses for one cycle with status, position and
// entries_left; the receiver must take it in that cycle, it cannot stall.
// A remove binary-searches: each probe is a memory read followed by a
// compare, and a miss ends when the search range is empty; a hit starts
// the shift-down, which moves one entry per cycle over the single read and
// single write port of the entry memory. Words are handled one at a time:
// busy drops as done rises, so the next word can be taken at the edge
// that takes the result.
// Reset clears the entry count and the controller; the entry memory is not
// cleared, only entries below the count are ever read.
`include "assert_macros.svh"

module sorted_key_table_remove_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic [skt_pkg::KEY_W-1:0]       key_primary,
  input  logic [skt_pkg::KEY_W-1:0]       key_secondary,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [skt_pkg::ADDR_W-1:0]      position,
  output logic [skt_pkg::CNT_W-1:0]       entries_left
);

  skt_pkg::skt_cmd_t  cmd;
  skt_pkg::skt_stat_t stat;

  skt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  skt_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .key_primary   (key_primary),
    .key_secondary (key_secondary),
    .done          (done),
    .status        (status),
    .position      (position),
    .entries_left  (entries_left)
  );

  // Check terms
  logic cnt_over;
  logic app_word;
  logic miss_word;
  assign cnt_over  = entries_left > skt_pkg::CNT_W'(skt_pkg::TABLE_DEPTH);
  assign app_word  = done && (status == skt_pkg::ST_APPENDED);
  assign miss_word = done && (status == skt_pkg::ST_NOTFOUND || status == skt_pkg::ST_FULL);

  // Checks
  `SKT_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy low after accept")
  `SKT_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe held too long")
  `SKT_ASSERT_NOW(a_count_range, clk, rst, done, !cnt_over, "entry count above table depth")
  `SKT_ASSERT_NOW(a_append_nonzero, clk, rst, app_word, |entries_left, "empty table after append")
  `SKT_ASSERT_NOW(a_miss_pos_zero, clk, rst, miss_word, ~|position, "nonzero position on a miss")

endmodule

// File: design/skt_ctrl.sv
module skt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               kind,
  input  skt_pkg::skt_stat_t stat,
  output skt_pkg::skt_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_APPEND = 5'b00010,
    S_PROBE  = 5'b00100,
    S_CMP    = 5'b01000,
    S_SHIFT  = 5'b10000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (kind == skt_pkg::KIND_REMOVE) ? S_PROBE : S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.fin = 1'b1;
        if (stat.full) begin
          cmd.fin_status = skt_pkg::ST_FULL;
        end else begin
          cmd.append     = 1'b1;
          cmd.fin_status = skt_pkg::ST_APPENDED;
        end
        state_next = S_IDLE;
      end
      S_PROBE: begin
        // empty range covers the empty table too
        if (stat.search_done) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = skt_pkg::ST_NOTFOUND;
          state_next     = S_IDLE;
        end else begin
          cmd.probe  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.key_eq) begin
          cmd.hit    = 1'b1;
          state_next = S_SHIFT;
        end else begin
          cmd.narrow = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (!stat.shift_more) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = skt_pkg::ST_REMOVED;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: design/skt_datapath.sv
module skt_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  skt_pkg::skt_cmd_t                   cmd,
  output skt_pkg::skt_stat_t                  stat,
  input  logic [skt_pkg::KEY_W-1:0]           key_primary,
  input  logic [skt_pkg::KEY_W-1:0]           key_secondary,
  output logic                                done,
  output logic [1:0]                          status,
  output logic [skt_pkg::ADDR_W-1:0]          position,
  output logic [skt_pkg::CNT_W-1:0]           entries_left
);

  localparam int AW = skt_pkg::ADDR_W;
  localparam int CW = skt_pkg::CNT_W;
  localparam int EW = skt_pkg::ENTRY_W;

  logic [EW-1:0] mem [skt_pkg::TABLE_DEPTH];

  logic [EW-1:0] key;
  logic [EW-1:0] rd_data;
  logic [CW-1:0] count;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi_ex;     // one past the top of the search range
  logic [AW-1:0] mid_reg;
  logic [AW-1:0] at;
  logic [CW-1:0] sp;        // next entry to read in the shift sweep
  logic [AW-1:0] wp;        // next entry to write in the shift sweep
  logic          pend;      // read data waits to be written back

  logic [CW-1:0] mid_sum;
  logic [AW-1:0] mid;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // Middle of range, lower middle on even size
  always_comb begin
    mid_sum = lo + hi_ex - CW'(1);
    mid     = mid_sum[AW:1];
  end

  // Status to controller
  always_comb begin
    stat.full        = (count >= CW'(skt_pkg::TABLE_DEPTH));
    stat.search_done = (lo >= hi_ex);
    stat.key_eq      = (key == rd_data);
    stat.shift_more  = (sp < count);
  end

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid;
    if (cmd.probe) begin
      rd_en = 1'b1;
    end else if (cmd.shift && stat.shift_more) begin
      rd_en   = 1'b1;
      rd_addr = sp[AW-1:0];
    end
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = key;
    if (cmd.append) begin
      wr_en = 1'b1;
    end else if (cmd.shift && pend) begin
      wr_en   = 1'b1;
      wr_addr = wp;
      wr_data = rd_data;
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Search and shift registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key   <= {key_primary, key_secondary};
      lo    <= '0;
      hi_ex <= count;
    end
    if (cmd.probe) begin
      mid_reg <= mid;
    end
    if (cmd.narrow) begin
      if (key < rd_data) begin
        hi_ex <= CW'(mid_reg);
      end else begin
        lo <= CW'(mid_reg) + CW'(1);
      end
    end
    if (cmd.hit) begin
      at <= mid_reg;
      wp <= mid_reg;
      sp <= CW'(mid_reg) + CW'(1);
    end
    if (cmd.shift) begin
      if (stat.shift_more) begin
        sp <= sp + CW'(1);
      end
      if (pend) begin
        wp <= wp + AW'(1);
      end
    end
  end

  // Control state: count, pending flag, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.fin;
      if (cmd.load) begin
        pend <= 1'b0;
      end else if (cmd.shift) begin
        pend <= stat.shift_more;
      end
      if (cmd.fin) begin
        case (cmd.fin_status)
          skt_pkg::ST_APPENDED: count <= count + CW'(1);
          skt_pkg::ST_REMOVED:  count <= count - CW'(1);
          default:              count <= count;
        endcase
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      status <= cmd.fin_status;
      case (cmd.fin_status)
        skt_pkg::ST_APPENDED: begin
          position     <= count[AW-1:0];
          entries_left <= count + CW'(1);
        end
        skt_pkg::ST_REMOVED: begin
          position     <= at;
          entries_left <= count - CW'(1);
        end
        default: begin
          position     <= '0;
          entries_left <= count;
        end
      endcase
    end
  end

endmodule
